// ===== sv/word_frame_crc_serializer_core_macros.svh =====
// Assertion helpers shared by the serializer modules.
`ifndef WORD_FRAME_CRC_SERIALIZER_CORE_MACROS_SVH
`define WORD_FRAME_CRC_SERIALIZER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WFCS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wfcs: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WFCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wfcs: next-cycle check failed");

`endif

// ===== sv/wfcs_pkg.sv =====
`default_nettype none
package wfcs_pkg;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'h0000;
    localparam int          QUEUE_DEPTH = 2;

    // Front sequencer: high byte of a word, then low byte
    typedef enum logic {
        FR_IDLE,
        FR_LOW
    } front_state_t;

    // One classified word handed from front to back
    typedef struct packed {
        logic [15:0] word;
        logic        eof;
        logic        first;
        logic [15:0] crc;
    } entry_t;

    // Shift eight message bits, MSB first, into the CRC register
    function automatic logic [15:0] crc_shift8(input logic [15:0] crc, input logic [7:0] din);
        logic [15:0] r;
        logic        top;
        r = crc;
        for (int b = 7; b >= 0; b--) begin
            top = r[15];
            r   = {r[14:0], din[b]};
            if (top) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/wfcs_front.sv =====
`default_nettype none
`include "word_frame_crc_serializer_core_macros.svh"
module wfcs_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [15:0]      s_data_word,
    input  wire logic             s_end_of_frame,
    output logic                  push_valid,
    output wfcs_pkg::entry_t      push_data,
    input  wire logic             push_ready
);

    wfcs_pkg::front_state_t state_reg, state_next;

    logic [15:0] crc_reg, crc_next;
    logic        first_reg, first_next;
    logic [15:0] word_reg, word_next;
    logic        eof_reg, eof_next;
    logic        wfirst_reg, wfirst_next;
    logic        accept;
    logic [15:0] crc_word;

    assign accept = s_valid && s_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wfcs_pkg::FR_IDLE: begin
                if (accept) state_next = wfcs_pkg::FR_LOW;
            end
            wfcs_pkg::FR_LOW: begin
                state_next = wfcs_pkg::FR_IDLE;
            end
            default: state_next = wfcs_pkg::FR_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready    = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            wfcs_pkg::FR_IDLE: s_ready    = push_ready;
            wfcs_pkg::FR_LOW:  push_valid = 1'b1;
            default: begin
                s_ready    = 1'b0;
                push_valid = 1'b0;
            end
        endcase
    end

    // CRC after the low byte of the held word
    assign crc_word = wfcs_pkg::crc_shift8(crc_reg, word_reg[7:0]);

    assign push_data.word  = word_reg;
    assign push_data.eof   = eof_reg;
    assign push_data.first = wfirst_reg;
    assign push_data.crc   = crc_word;

    // Running CRC and frame tracking
    always_comb begin
        crc_next    = crc_reg;
        first_next  = first_reg;
        word_next   = word_reg;
        eof_next    = eof_reg;
        wfirst_next = wfirst_reg;
        if (accept) begin
            crc_next    = wfcs_pkg::crc_shift8(crc_reg, s_data_word[15:8]);
            word_next   = s_data_word;
            eof_next    = s_end_of_frame;
            wfirst_next = first_reg;
        end else if (push_valid) begin
            if (eof_reg) begin
                crc_next   = wfcs_pkg::CRC_INIT;
                first_next = 1'b1;
            end else begin
                crc_next   = crc_word;
                first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wfcs_pkg::FR_IDLE;
            crc_reg   <= wfcs_pkg::CRC_INIT;
            first_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            crc_reg   <= crc_next;
            first_reg <= first_next;
        end
    end

    // Held word, no reset needed
    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        eof_reg    <= eof_next;
        wfirst_reg <= wfirst_next;
    end

    `WFCS_ASSERT_NEXT(a_accept_then_push, aclk, aresetn, accept, push_valid)
    `WFCS_ASSERT_IMPL(a_push_has_room, aclk, aresetn, push_valid, push_ready)

endmodule
`default_nettype wire

// ===== sv/wfcs_queue.sv =====
`default_nettype none
`include "word_frame_crc_serializer_core_macros.svh"
module wfcs_queue #(
    parameter int DEPTH = wfcs_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire wfcs_pkg::entry_t in_data,
    output logic                  in_ready,
    output logic                  out_valid,
    output wfcs_pkg::entry_t      out_data,
    input  wire logic             out_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wfcs_pkg::entry_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `WFCS_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `WFCS_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule
`default_nettype wire

// ===== sv/wfcs_back.sv =====
`default_nettype none
`include "word_frame_crc_serializer_core_macros.svh"
module wfcs_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    input  wire wfcs_pkg::entry_t q_data,
    output logic                  q_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_is_crc_byte,
    output logic                  m_last_byte
);

    localparam logic [1:0] IDX_DATA0  = 2'd0;
    localparam logic [1:0] IDX_DATA1  = 2'd1;
    localparam logic [1:0] IDX_CRC_LO = 2'd2;
    localparam logic [1:0] IDX_CRC_HI = 2'd3;

    wfcs_pkg::entry_t cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [1:0]       idx_reg, idx_next;
    logic [15:0]      aug_reg, aug_next;
    logic             aug_done_reg, aug_done_next;
    logic             beat, end_of_entry, pop;

    assign m_valid      = cur_valid_reg;
    assign beat         = m_valid && m_ready;
    assign end_of_entry = (idx_reg == IDX_DATA1 && !cur_reg.eof) || (idx_reg == IDX_CRC_HI);
    assign q_ready      = !cur_valid_reg || (beat && end_of_entry);
    assign pop          = q_valid && q_ready;

    // Byte select for the current beat
    always_comb begin
        m_out_byte = cur_reg.word[7:0];
        unique case (idx_reg)
            IDX_DATA0:  m_out_byte = cur_reg.first ? cur_reg.word[15:8] : cur_reg.word[7:0];
            IDX_DATA1:  m_out_byte = cur_reg.first ? cur_reg.word[7:0] : cur_reg.word[15:8];
            IDX_CRC_LO: m_out_byte = aug_reg[7:0];
            IDX_CRC_HI: m_out_byte = aug_reg[15:8];
            default:    m_out_byte = cur_reg.word[7:0];
        endcase
    end

    assign m_is_crc_byte = (idx_reg == IDX_CRC_LO) || (idx_reg == IDX_CRC_HI);
    assign m_last_byte   = idx_reg == IDX_CRC_HI;

    // Entry load, byte index and zero-word augmentation as two zero-byte CRC shifts
    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        aug_next       = aug_reg;
        aug_done_next  = aug_done_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            cur_next       = q_data;
            idx_next       = IDX_DATA0;
            aug_next       = wfcs_pkg::crc_shift8(q_data.crc, 8'h00);
            aug_done_next  = 1'b0;
        end else begin
            if (beat) begin
                if (end_of_entry) begin
                    cur_valid_next = 1'b0;
                end
                idx_next = idx_reg + 1'b1;
            end
            if (cur_valid_reg && !aug_done_reg) begin
                aug_next      = wfcs_pkg::crc_shift8(aug_reg, 8'h00);
                aug_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= IDX_DATA0;
            aug_done_reg  <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            aug_done_reg  <= aug_done_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        aug_reg <= aug_next;
    end

    `WFCS_ASSERT_IMPL(a_crc_only_on_eof, aclk, aresetn, cur_valid_reg && m_is_crc_byte, cur_reg.eof)
    `WFCS_ASSERT_IMPL(a_crc_ready, aclk, aresetn, cur_valid_reg && m_is_crc_byte, aug_done_reg)

endmodule
`default_nettype wire

// ===== sv/word_frame_crc_serializer_core.sv =====
// A word passes the front's held word, the queue and the back's entry register.
// Words enter as older ones serialize; a last word takes 4 output beats (2 data, 2 CRC).
// The front folds 8 CRC bits per cycle unless stalled; the back sends one byte per beat.
// A 2-entry queue decouples front and back so each side stalls on its own.
// Reset: aresetn synchronous active low; CRC returns to 0 and the next word opens a frame.
`default_nettype none
module word_frame_crc_serializer_core #(
    parameter int QUEUE_DEPTH = wfcs_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_data_word,
    input  wire logic        s_end_of_frame,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_is_crc_byte,
    output logic             m_last_byte
);

    logic             push_valid, push_ready;
    wfcs_pkg::entry_t push_data;
    logic             q_valid, q_ready;
    wfcs_pkg::entry_t q_data;

    // Word intake and running CRC
    wfcs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_end_of_frame(s_end_of_frame),
        .push_valid    (push_valid),
        .push_data     (push_data),
        .push_ready    (push_ready)
    );

    // Decoupling queue
    wfcs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_data  (push_data),
        .in_ready (push_ready),
        .out_valid(q_valid),
        .out_data (q_data),
        .out_ready(q_ready)
    );

    // Byte serializer
    wfcs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_ready      (q_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_is_crc_byte(m_is_crc_byte),
        .m_last_byte  (m_last_byte)
    );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_WORDS = 400;
    localparam int QUIET_TAIL   = 60;

    // One serialized byte as the block should emit it
    typedef struct packed {
        logic [7:0] data;
        logic       crc_flag;
        logic       last_flag;
    } tx_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_data_word;
    logic        s_end_of_frame;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_is_crc_byte;
    logic        m_last_byte;

    // Predictor state: running CRC and frame-open flag
    logic [15:0] crc_acc;
    logic        frame_open;
    tx_byte_t    pending_bytes[$];
    tx_byte_t    head_byte;

    int          mismatch_count;
    int          stall_cycles;
    bit          quiet_phase;

    word_frame_crc_serializer_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_is_crc_byte  (m_is_crc_byte),
        .m_last_byte    (m_last_byte)
    );

    initial aclk = 1'b0;
    always #(CLK_HALF) aclk = ~aclk;

    // Bit-serial CRC-16 step, one word MSB first, augmented register form
    function automatic logic [15:0] crc_fold_word(input logic [15:0] crc,
                                                  input logic [15:0] w);
        logic [15:0] r;
        logic        top;
        r = crc;
        for (int b = 15; b >= 0; b--) begin
            top = r[15];
            r   = {r[14:0], w[b]};
            if (top) begin
                r = r ^ 16'h1021;
            end
        end
        return r;
    endfunction

    // Queue the bytes one accepted word should produce
    task automatic predict_word_bytes(input logic [15:0] w, input logic eof);
        logic [15:0] crc_out;
        if (frame_open) begin
            pending_bytes.push_back('{w[15:8], 1'b0, 1'b0});
            pending_bytes.push_back('{w[7:0], 1'b0, 1'b0});
        end else begin
            pending_bytes.push_back('{w[7:0], 1'b0, 1'b0});
            pending_bytes.push_back('{w[15:8], 1'b0, 1'b0});
        end
        crc_acc    = crc_fold_word(crc_acc, w);
        frame_open = 1'b0;
        if (eof) begin
            // flush with one zero word, send low byte then high byte
            crc_out = crc_fold_word(crc_acc, 16'h0000);
            pending_bytes.push_back('{crc_out[7:0], 1'b1, 1'b0});
            pending_bytes.push_back('{crc_out[15:8], 1'b1, 1'b1});
            crc_acc    = 16'h0000;
            frame_open = 1'b1;
        end
    endtask

    // Drive one word beat; called and returns at a falling edge
    task automatic send_word(input logic [15:0] w, input logic eof);
        int gap;
        gap = 0;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_word    <= w;
        s_end_of_frame <= eof;
        do @(posedge aclk); while (!s_ready);
        predict_word_bytes(w, eof);
        @(negedge aclk);
    endtask

    // Random word with a bias toward all-zero and all-one patterns
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Extremes, single-word frames and short multi-word frames
    task automatic test_directed_frames();
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h8000, 1'b1);
        send_word(16'h0001, 1'b1);
        send_word(16'h1234, 1'b0);
        send_word(16'hABCD, 1'b1);
        send_word(16'hFF00, 1'b0);
        send_word(16'h00FF, 1'b0);
        send_word(16'h1021, 1'b1);
        repeat (3) send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b1);
        repeat (3) send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b1);
    endtask

    // Sender holds off until the output side has fully drained
    task automatic test_drain_pause();
        send_word(16'h5A5A, 1'b0);
        send_word(16'hA5A5, 1'b0);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_bytes.size() != 0);
        send_word(16'hC3C3, 1'b1);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_bytes.size() != 0);
    endtask

    // Random frames, mostly short with the odd long one
    task automatic test_random_frames();
        int remaining;
        int frame_len;
        remaining = RANDOM_WORDS;
        while (remaining > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                frame_len = $urandom_range(13, 40);
            end else begin
                frame_len = $urandom_range(1, 6);
            end
            if (frame_len > remaining) begin
                frame_len = remaining;
            end
            for (int k = 0; k < frame_len; k++) begin
                quiet_phase = (remaining <= QUIET_TAIL);
                send_word(pick_word(), k == frame_len - 1);
                remaining--;
            end
        end
    endtask

    // Output sink with random back-pressure bursts
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
            if (!quiet_phase && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
        end
    end

    // Compare each output beat against the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected beat: out_byte=%h is_crc_byte=%b last_byte=%b",
                       m_out_byte, m_is_crc_byte, m_last_byte);
                mismatch_count++;
            end else begin
                head_byte = pending_bytes.pop_front();
                if (m_out_byte !== head_byte.data) begin
                    $error("out_byte: expected %h, actual %h", head_byte.data, m_out_byte);
                    mismatch_count++;
                end
                if (m_is_crc_byte !== head_byte.crc_flag) begin
                    $error("is_crc_byte: expected %b, actual %b",
                           head_byte.crc_flag, m_is_crc_byte);
                    mismatch_count++;
                end
                if (m_last_byte !== head_byte.last_flag) begin
                    $error("last_byte: expected %b, actual %b",
                           head_byte.last_flag, m_last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data_word    = 16'h0000;
        s_end_of_frame = 1'b0;
        crc_acc        = 16'h0000;
        frame_open     = 1'b1;
        mismatch_count = 0;
        stall_cycles   = 0;
        quiet_phase    = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_frames();
        test_drain_pause();
        test_random_frames();
        s_valid <= 1'b0;

        // drain, then give the block time to show any stray beat
        do @(negedge aclk); while (pending_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && pending_bytes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
